>>> design/essc_pkg.sv
// ----------------------------------------------------------------------------
// Extent slice splitter package
// Shared widths, codes, payload types and the controller/datapath handshake.
// ----------------------------------------------------------------------------
package essc_pkg;

  // Parameter defaults for the top level.
  localparam int MAX_PIECES_DEF = 64;
  localparam int POS_BITS_DEF   = 48;

  // Fixed field widths.
  localparam int FID_W      = 32;
  localparam int FPOS_W     = 48;
  localparam int LEN_W      = 32;
  localparam int ELEN_W     = 48;
  localparam int SLOT_W     = 24;
  localparam int CNT_W      = 25;
  localparam int SHIFT_W    = 6;
  localparam int CFG_DATA_W = 25;
  localparam int CFG_IDX_W  = 1;
  localparam int WORD_W     = 64;

  // Register reset values.
  localparam logic [SHIFT_W-1:0] SHIFT_RESET    = 6'd20;
  localparam logic [CNT_W-1:0]   CAPACITY_RESET = 25'd65536;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLICE_SHIFT    = 1'b0,
    CFG_INDEX_CAPACITY = 1'b1
  } cfg_reg_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_RECORDED   = 2'd0,
    ST_TABLE_FULL = 2'd1,
    ST_TOO_MANY   = 2'd2
  } status_t;

  typedef struct packed {
    logic [FID_W-1:0]  file_id;
    logic [FPOS_W-1:0] file_offset;
    logic [FPOS_W-1:0] mem_pos;
    logic [LEN_W-1:0]  length;
  } extent_t;

  typedef struct packed {
    logic [FID_W-1:0]  entry_file_id;
    logic [FPOS_W-1:0] entry_file_pos;
    logic [FPOS_W-1:0] entry_mem_pos;
    logic [ELEN_W-1:0] entry_length;
    logic [SLOT_W-1:0] entry_slot;
    logic              is_update;
    status_t           status;
    logic              last_of_run;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic calc_end;
    logic calc_shift;
    logic calc_count;
    logic decide;
    logic piece;
    logic emit;
    logic reject;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic reject_needed;
    logic piece_last;
    logic out_free;
  } dp_status_t;

endpackage

>>> design/essc_in_if.sv
// ----------------------------------------------------------------------------
// Extent input channel
// Valid/ready channel carrying one write extent per transaction.
// ----------------------------------------------------------------------------
interface essc_in_if;
  logic                        valid;
  logic                        ready;
  logic [essc_pkg::FID_W-1:0]  file_id;
  logic [essc_pkg::FPOS_W-1:0] file_offset;
  logic [essc_pkg::FPOS_W-1:0] mem_pos;
  logic [essc_pkg::LEN_W-1:0]  length;

  modport source (output valid, output file_id, output file_offset, output mem_pos,
                  output length, input ready);
  modport sink (input valid, input file_id, input file_offset, input mem_pos,
                input length, output ready);
endinterface

>>> design/essc_out_if.sv
// ----------------------------------------------------------------------------
// Index entry output channel
// Valid/ready channel carrying one index-table result per transaction.
// ----------------------------------------------------------------------------
interface essc_out_if;
  logic                        valid;
  logic                        ready;
  logic [essc_pkg::FID_W-1:0]  entry_file_id;
  logic [essc_pkg::FPOS_W-1:0] entry_file_pos;
  logic [essc_pkg::FPOS_W-1:0] entry_mem_pos;
  logic [essc_pkg::ELEN_W-1:0] entry_length;
  logic [essc_pkg::SLOT_W-1:0] entry_slot;
  logic                        is_update;
  logic [1:0]                  status;
  logic                        last_of_run;

  modport source (output valid, output entry_file_id, output entry_file_pos,
                  output entry_mem_pos, output entry_length, output entry_slot,
                  output is_update, output status, output last_of_run, input ready);
  modport sink (input valid, input entry_file_id, input entry_file_pos,
                input entry_mem_pos, input entry_length, input entry_slot,
                input is_update, input status, input last_of_run, output ready);
endinterface

>>> design/essc_ctrl.sv
// ----------------------------------------------------------------------------
// Extent slice splitter controller
// One-hot sequencer stepping the datapath through check and emission phases.
// ----------------------------------------------------------------------------
module essc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  essc_pkg::dp_status_t sts,
  output essc_pkg::ctl_cmd_t   cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_END    = 8'b0000_0010,
    S_SHIFT  = 8'b0000_0100,
    S_COUNT  = 8'b0000_1000,
    S_DECIDE = 8'b0001_0000,
    S_PIECE  = 8'b0010_0000,
    S_EMIT   = 8'b0100_0000,
    S_REJECT = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  // No extent is taken while reset is held.
  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.load       = in_valid && in_ready;
    cmd.calc_end   = (state == S_END);
    cmd.calc_shift = (state == S_SHIFT);
    cmd.calc_count = (state == S_COUNT);
    cmd.decide     = (state == S_DECIDE);
    cmd.piece      = (state == S_PIECE);
    cmd.emit       = (state == S_EMIT);
    cmd.reject     = (state == S_REJECT);
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) state_next = S_END;
      end
      S_END:    state_next = S_SHIFT;
      S_SHIFT:  state_next = S_COUNT;
      S_COUNT:  state_next = S_DECIDE;
      S_DECIDE: state_next = sts.reject_needed ? S_REJECT : S_PIECE;
      S_PIECE:  state_next = S_EMIT;
      S_EMIT: begin
        if (sts.out_free) state_next = sts.piece_last ? S_IDLE : S_PIECE;
      end
      S_REJECT: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // An accepted extent always goes straight to the end-position check.
  a_load_then_end: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.calc_end)
    else $error("accepted extent did not start its checks");

  // Emission is only entered from a freshly computed piece.
  a_emit_follows_piece: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && !$past(cmd.emit)) |-> $past(cmd.piece))
    else $error("emission entered without a computed piece");

  // The sequencer is always in exactly one state.
  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("sequencer state is not one-hot");

endmodule

>>> design/essc_dp.sv
// ----------------------------------------------------------------------------
// Extent slice splitter datapath
// Configuration, table state, piece arithmetic and the result register.
// ----------------------------------------------------------------------------
module essc_dp #(
  parameter int MAX_PIECES = essc_pkg::MAX_PIECES_DEF,
  parameter int POS_BITS   = essc_pkg::POS_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [essc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [essc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  essc_pkg::extent_t                   ext,
  input  essc_pkg::ctl_cmd_t                  cmd,
  output essc_pkg::dp_status_t                sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output essc_pkg::entry_t                    out_data
);

  localparam int PB  = POS_BITS;
  localparam int SW  = ((PB > essc_pkg::FPOS_W) ? PB : essc_pkg::FPOS_W) + 1;
  localparam int PCW = $clog2(MAX_PIECES + 1);
  localparam int LW  = essc_pkg::LEN_W;
  localparam int EW  = essc_pkg::ELEN_W;
  localparam int CW  = essc_pkg::CNT_W;
  localparam logic [essc_pkg::FPOS_W-1:0] MEM_MASK = (PB >= essc_pkg::FPOS_W) ?
      {essc_pkg::FPOS_W{1'b1}} :
      essc_pkg::FPOS_W'((64'd1 << PB) - 64'd1);

  // Configuration registers.
  logic [essc_pkg::SHIFT_W-1:0] slice_shift;
  logic [CW-1:0]                index_capacity;

  // Latched extent.
  logic [essc_pkg::FID_W-1:0]  x_fid;
  logic [PB-1:0]               x_pos;
  logic [essc_pkg::FPOS_W-1:0] x_mem;
  logic [LW-1:0]               x_len;

  // Check results.
  logic [PB-1:0]  x_end;
  logic           ovf;
  logic [PB-1:0]  hi_end;
  logic [PB-1:0]  hi_pos;
  logic           coalesce;
  logic           too_many;
  logic [PCW-1:0] pieces;

  // Piece walk.
  logic [PB-1:0]               start;
  logic [essc_pkg::FPOS_W-1:0] mem_cur;
  logic                        first;
  logic [PB-1:0]               pc_start;
  logic [PB-1:0]               pc_next;
  logic [LW-1:0]               pc_len;
  logic                        pc_last;

  // Index-table state.
  logic [CW-1:0]              entry_count;
  logic [essc_pkg::FID_W-1:0] last_entry_file;
  logic [PB-1:0]              last_entry_start;
  logic [EW-1:0]              last_entry_len;

  logic [PB-1:0] smask;
  logic [PB:0]   end_sum;
  logic [SW-1:0] last_sum;
  logic          same_slice;
  logic [PB-1:0] diff;
  logic          full;
  logic [PB-1:0] send;
  logic          plast;
  logic [PB-1:0] pend;
  logic [EW:0]   nl_sum;
  logic [EW-1:0] nl;
  logic          out_free;
  logic          emit_fire;
  logic          reject_fire;
  logic [essc_pkg::WORD_W-1:0] fpos64;
  logic [essc_pkg::WORD_W-1:0] xpos64;
  logic [essc_pkg::WORD_W-1:0] pcs64;
  logic [essc_pkg::WORD_W-1:0] ls64;

  // Low-bit mask of one slice.
  always_comb begin
    for (int j = 0; j < PB; j++) begin
      smask[j] = (7'(j) < 7'(slice_shift));
    end
  end

  assign fpos64 = essc_pkg::WORD_W'(ext.file_offset);
  assign xpos64 = essc_pkg::WORD_W'(x_pos);
  assign pcs64  = essc_pkg::WORD_W'(pc_start);
  assign ls64   = essc_pkg::WORD_W'(last_entry_start);

  assign end_sum    = {1'b0, x_pos} + (PB + 1)'(x_len) - (PB + 1)'(1);
  assign last_sum   = SW'(last_entry_start) + SW'(last_entry_len);
  assign same_slice = (((last_entry_start ^ x_pos) & ~smask) == '0);
  assign diff       = hi_end - hi_pos;
  assign full       = ({1'b0, entry_count} + (CW + 1)'(pieces)) >= {1'b0, index_capacity};

  assign send  = start | smask;
  assign plast = (send >= x_end);
  assign pend  = plast ? x_end : send;

  assign nl_sum = {1'b0, last_entry_len} + (EW + 1)'(pc_len);
  assign nl     = nl_sum[EW] ? {EW{1'b1}} : nl_sum[EW-1:0];

  assign out_free    = !out_valid || out_ready;
  assign emit_fire   = cmd.emit && out_free;
  assign reject_fire = cmd.reject && out_free;

  assign sts.reject_needed = ovf || too_many || full;
  assign sts.piece_last    = pc_last;
  assign sts.out_free      = out_free;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      slice_shift    <= essc_pkg::SHIFT_RESET;
      index_capacity <= essc_pkg::CAPACITY_RESET;
    end else if (cfg_we) begin
      unique case (essc_pkg::cfg_reg_t'(cfg_index))
        essc_pkg::CFG_SLICE_SHIFT:    slice_shift    <= cfg_data[essc_pkg::SHIFT_W-1:0];
        essc_pkg::CFG_INDEX_CAPACITY: index_capacity <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // Extent checks and piece computation.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_fid <= ext.file_id;
      x_pos <= fpos64[PB-1:0];
      x_mem <= ext.mem_pos;
      x_len <= ext.length;
    end
    if (cmd.calc_end) begin
      ovf   <= (x_len != '0) && end_sum[PB];
      x_end <= (x_len == '0) ? x_pos : end_sum[PB-1:0];
    end
    if (cmd.calc_shift) begin
      hi_end   <= x_end >> slice_shift;
      hi_pos   <= x_pos >> slice_shift;
      coalesce <= (entry_count != '0) && (last_entry_file == x_fid) &&
                  (last_sum == SW'(x_pos)) && same_slice;
    end
    if (cmd.calc_count) begin
      too_many <= (diff > PB'(MAX_PIECES - 1));
      pieces   <= PCW'(diff) + PCW'(1);
    end
    if (cmd.piece) begin
      pc_start <= start;
      pc_next  <= send + PB'(1);
      pc_last  <= plast;
      pc_len   <= (x_len == '0) ? '0 : LW'(pend - start) + LW'(1);
    end
  end

  // Walk pointers and index-table state.
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      start   <= x_pos;
      mem_cur <= x_mem;
      first   <= 1'b1;
    end else if (emit_fire) begin
      start   <= pc_next;
      mem_cur <= mem_cur + essc_pkg::FPOS_W'(pc_len);
      first   <= 1'b0;
    end
    if (rst) begin
      entry_count      <= '0;
      last_entry_file  <= '0;
      last_entry_start <= '0;
      last_entry_len   <= '0;
    end else if (emit_fire) begin
      if (first && coalesce) begin
        last_entry_len <= nl;
      end else begin
        last_entry_file  <= x_fid;
        last_entry_start <= pc_start;
        last_entry_len   <= EW'(pc_len);
        entry_count      <= entry_count + CW'(1);
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire || reject_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (emit_fire) begin
      out_data.entry_file_id <= x_fid;
      out_data.entry_mem_pos <= mem_cur & MEM_MASK;
      out_data.status        <= essc_pkg::ST_RECORDED;
      out_data.last_of_run   <= pc_last;
      if (first && coalesce) begin
        out_data.entry_file_pos <= ls64[essc_pkg::FPOS_W-1:0];
        out_data.entry_length   <= nl;
        out_data.entry_slot     <= essc_pkg::SLOT_W'(entry_count - CW'(1));
        out_data.is_update      <= 1'b1;
      end else begin
        out_data.entry_file_pos <= pcs64[essc_pkg::FPOS_W-1:0];
        out_data.entry_length   <= EW'(pc_len);
        out_data.entry_slot     <= essc_pkg::SLOT_W'(entry_count);
        out_data.is_update      <= 1'b0;
      end
    end else if (reject_fire) begin
      out_data.entry_file_id  <= x_fid;
      out_data.entry_file_pos <= xpos64[essc_pkg::FPOS_W-1:0];
      out_data.entry_mem_pos  <= x_mem;
      out_data.entry_length   <= EW'(x_len);
      out_data.entry_slot     <= essc_pkg::SLOT_W'(entry_count);
      out_data.is_update      <= 1'b0;
      out_data.status         <= (ovf || too_many) ? essc_pkg::ST_TOO_MANY
                                                   : essc_pkg::ST_TABLE_FULL;
      out_data.last_of_run    <= 1'b1;
    end
  end

  // The entry count moves by at most one per cycle and never goes back.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (entry_count == $past(entry_count)) ||
                    (entry_count == $past(entry_count) + CW'(1)))
    else $error("entry count moved by more than one");

  // A piece that is not the last one always moves the walk forward.
  a_walk_advances: assert property (@(posedge clk) disable iff (rst)
    (emit_fire && !pc_last) |=> (start > $past(start)))
    else $error("slice walk did not advance");

  // Rejections never touch the table state.
  a_reject_keeps_state: assert property (@(posedge clk) disable iff (rst)
    reject_fire |=> $stable(entry_count) && $stable(last_entry_len))
    else $error("rejected extent changed the table state");

endmodule

>>> design/extent_slice_splitter_coalescer_top.sv
// ----------------------------------------------------------------------------
// Extent slice splitter and index coalescer
// Cuts each write extent at slice boundaries and records one index entry per
// piece, lengthening the last entry when the first piece continues it.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Transaction                          Payload
//  -------   ---   -----------------------------------  --------------------------
//  extent    in    one write extent                     file_id, file_offset,
//                                                       mem_pos, length
//  entry     out   one recorded, updated or             entry_* fields, is_update,
//                  rejected index entry                 status, last_of_run
//  cfg_*     in    register write (0 slice_shift,       cfg_index, cfg_data
//                  1 index_capacity)
//
//  An extent is accepted and then passes four check steps (end position,
//  slice numbers, piece count, capacity); each piece is then computed and
//  emitted in turn through the single result register, and a rejected
//  extent goes from the checks straight to its one result.
//  Reset (rst, synchronous) empties the index table, clears the last-entry
//  record and restores slice_shift to 20 and index_capacity to 65536; no
//  extent is taken while it is held.
//  A result waits in the output register while entry.ready is low; the
//  sequencer holds its piece until the register frees up. A new extent is
//  taken as soon as the last result of the previous one is in the register.
//
module extent_slice_splitter_coalescer_top #(
  parameter int MAX_PIECES = essc_pkg::MAX_PIECES_DEF,
  parameter int POS_BITS   = essc_pkg::POS_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [essc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [essc_pkg::CFG_DATA_W-1:0] cfg_data,
  essc_in_if.sink                         extent,
  essc_out_if.source                      entry
);

  essc_pkg::ctl_cmd_t   cmd;
  essc_pkg::dp_status_t sts;
  essc_pkg::extent_t    ext;
  essc_pkg::entry_t     out_data;
  logic                 out_valid;
  logic                 in_ready;

  // Pack the incoming extent for the datapath.
  assign ext.file_id     = extent.file_id;
  assign ext.file_offset = extent.file_offset;
  assign ext.mem_pos     = extent.mem_pos;
  assign ext.length      = extent.length;
  assign extent.ready    = in_ready;

  // The sequencer walks each extent through its checks and pieces.
  essc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (extent.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath owns configuration, the table record and the result register.
  essc_dp #(
    .MAX_PIECES (MAX_PIECES),
    .POS_BITS   (POS_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ext       (ext),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (entry.ready),
    .out_data  (out_data)
  );

  // Unpack the result register onto the output channel.
  assign entry.valid          = out_valid;
  assign entry.entry_file_id  = out_data.entry_file_id;
  assign entry.entry_file_pos = out_data.entry_file_pos;
  assign entry.entry_mem_pos  = out_data.entry_mem_pos;
  assign entry.entry_length   = out_data.entry_length;
  assign entry.entry_slot     = out_data.entry_slot;
  assign entry.is_update      = out_data.is_update;
  assign entry.status         = out_data.status;
  assign entry.last_of_run    = out_data.last_of_run;

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// Extent slice splitter testbench
// Drives write extents through the splitter, predicts every index entry
// with a local model of the index table, and compares the results in order.
// ----------------------------------------------------------------------------
module testbench;
  import essc_pkg::*;

  // Position space of the block at its default POS_BITS.
  localparam logic [63:0] POS_LIMIT    = 64'h0000_FFFF_FFFF_FFFF;
  localparam int          DRAIN_CYCLES = 5 + 2 * MAX_PIECES_DEF + 10;
  localparam int          PHASE_ITEMS  = 68;
  // Far beyond the slowest legal run, even with every extent at full size.
  localparam longint      RUN_LIMIT    = 64'd12 * 64'd1_500_000;

  typedef enum {ROW_EXTENT, ROW_CONFIG, ROW_CONFIG_REL} row_kind_t;

  // One row of the directed table. A config row writes both registers;
  // ROW_CONFIG_REL sets the capacity relative to the current entry count.
  typedef struct {
    row_kind_t   kind;
    extent_t     ext;
    bit          typed;
    entry_t      want;
    logic [24:0] shift_data;
    logic [24:0] cap_data;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  essc_in_if  ext_if();
  essc_out_if ent_if();

  extent_slice_splitter_coalescer_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .extent    (ext_if),
    .entry     (ent_if)
  );

  always #6 clk = ~clk;

  // Local copy of the block's registers and index-table bookkeeping.
  logic [5:0]  tbl_shift;
  logic [24:0] tbl_cap;
  logic [24:0] tbl_count;
  logic [31:0] tbl_last_file;
  logic [47:0] tbl_last_start;
  logic [47:0] tbl_last_len;

  // Entries the block still owes us, oldest first, and the entries that
  // the most recent extent produced.
  entry_t pending_entries[$];
  entry_t fresh_entries[$];

  int src_idle_pct;
  int snk_idle_pct;
  int mismatches;
  int results_seen;

  stim_row_t dir_table[$];

  // Splits one extent exactly as the block should, appends the expected
  // entries to fresh_entries and advances the table bookkeeping.
  function automatic void split_extent(input extent_t x);
    logic [63:0] pos, mem, len, fin, pieces, smask, start, send, pend, plen, nl;
    logic        merge;
    entry_t      e;
    int          sh;
    int          k;
    pos   = 64'(x.file_offset);
    mem   = 64'(x.mem_pos);
    len   = 64'(x.length);
    sh    = int'(tbl_shift);
    smask = (64'd1 << sh) - 64'd1;
    fresh_entries.delete();

    // A dropped extent comes back with its own fields and the next slot.
    e.entry_file_id  = x.file_id;
    e.entry_file_pos = x.file_offset;
    e.entry_mem_pos  = x.mem_pos;
    e.entry_length   = 48'(x.length);
    e.entry_slot     = tbl_count[23:0];
    e.is_update      = 1'b0;
    e.status         = ST_TOO_MANY;
    e.last_of_run    = 1'b1;

    // The last byte would fall beyond the position space.
    if (len != 0 && len - 64'd1 > POS_LIMIT - pos) begin
      fresh_entries.push_back(e);
      return;
    end
    fin    = (len == 0) ? pos : pos + len - 64'd1;
    pieces = (fin >> sh) - (pos >> sh) + 64'd1;
    if (pieces > 64'(MAX_PIECES_DEF)) begin
      fresh_entries.push_back(e);
      return;
    end
    // The capacity test counts a piece that would coalesce as well.
    if (64'(tbl_count) + pieces >= 64'(tbl_cap)) begin
      e.status = ST_TABLE_FULL;
      fresh_entries.push_back(e);
      return;
    end

    merge = (tbl_count != 0) && (tbl_last_file == x.file_id) &&
            (64'(tbl_last_start) + 64'(tbl_last_len) == pos) &&
            ((64'(tbl_last_start) >> sh) == (pos >> sh));

    start = pos;
    for (k = 0; k < int'(pieces); k++) begin
      send = start | smask;
      pend = (send < fin) ? send : fin;
      plen = (len == 0) ? 64'd0 : pend - start + 64'd1;
      e.entry_mem_pos = 48'(mem + (start - pos));
      e.last_of_run   = (k == int'(pieces) - 1);
      e.status        = ST_RECORDED;
      if (k == 0 && merge) begin
        nl = 64'(tbl_last_len) + plen;
        if (nl > POS_LIMIT) nl = POS_LIMIT;
        tbl_last_len     = 48'(nl);
        e.entry_file_pos = tbl_last_start;
        e.entry_length   = 48'(nl);
        e.entry_slot     = 24'(tbl_count - 25'd1);
        e.is_update      = 1'b1;
      end else begin
        e.entry_file_pos = 48'(start);
        e.entry_length   = 48'(plen);
        e.entry_slot     = tbl_count[23:0];
        e.is_update      = 1'b0;
        tbl_last_file    = x.file_id;
        tbl_last_start   = 48'(start);
        tbl_last_len     = 48'(plen);
        tbl_count        = tbl_count + 25'd1;
      end
      fresh_entries.push_back(e);
      start = (pend + 64'd1) & POS_LIMIT;
    end
  endfunction

  // Random length spanning at most about span slices at the current shift.
  function automatic logic [31:0] rand_length(input int span);
    logic [63:0] lim;
    if (tbl_shift >= 6'd32) begin
      lim = 64'hFFFF_FFFF;
    end else begin
      lim = 64'(span) << tbl_shift;
      if (lim > 64'hFFFF_FFFF) lim = 64'hFFFF_FFFF;
    end
    return 32'(({$urandom, $urandom} % lim) + 64'd1);
  endfunction

  // Mostly extents that continue the last entry or start a short new run,
  // with some long runs, rejects near the top of the space and zero lengths.
  function automatic extent_t make_extent();
    extent_t     x;
    int unsigned pick;
    pick = $urandom_range(99);
    x.file_id     = ($urandom_range(1) == 0) ? 32'($urandom_range(7)) : $urandom;
    x.file_offset = 48'({$urandom, $urandom});
    x.mem_pos     = 48'({$urandom, $urandom});
    x.length      = rand_length($urandom_range(1, 4));
    if ($urandom_range(3) == 0) x.file_offset = (x.file_offset >> tbl_shift) << tbl_shift;
    if (pick < 45 && tbl_count != 0) begin
      x.file_id     = tbl_last_file;
      x.file_offset = tbl_last_start + tbl_last_len;
      x.length      = rand_length($urandom_range(1, 3));
      // Now and then the continuation is off by a few bytes.
      if ($urandom_range(9) == 0) x.file_offset = x.file_offset + 48'($urandom_range(1, 3));
    end else if (pick < 57) begin
      x.length = rand_length($urandom_range(5, 70));
    end else if (pick < 67) begin
      x.length = $urandom;
      if ($urandom_range(1) == 0) x.file_offset = ~48'($urandom);
    end
    if ($urandom_range(19) == 0) x.length = '0;
    return x;
  endfunction

  function automatic stim_row_t ext_row(input logic [31:0] fid, input logic [47:0] pos,
                                        input logic [47:0] mem, input logic [31:0] len);
    stim_row_t r;
    r.kind       = ROW_EXTENT;
    r.ext        = '{fid, pos, mem, len};
    r.typed      = 1'b0;
    r.want       = '0;
    r.shift_data = '0;
    r.cap_data   = '0;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input logic [31:0] fid, input logic [47:0] pos,
                                          input logic [47:0] mem, input logic [31:0] len,
                                          input logic [47:0] efpos, input logic [47:0] emem,
                                          input logic [47:0] elen, input logic [23:0] slot,
                                          input logic upd, input status_t st);
    stim_row_t r;
    r       = ext_row(fid, pos, mem, len);
    r.typed = 1'b1;
    r.want  = '{fid, efpos, emem, elen, slot, upd, st, 1'b1};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input row_kind_t kind, input logic [24:0] shift_data,
                                        input logic [24:0] cap_data);
    stim_row_t r;
    r            = ext_row('0, '0, '0, '0);
    r.kind       = kind;
    r.shift_data = shift_data;
    r.cap_data   = cap_data;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH result %0d %s: got %0h, want %0h", results_seen, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Presents one extent, holds it until the block takes it, and then books
  // the entries it must produce. A typed row supplies its single result.
  task automatic drive_extent(input extent_t x, input bit typed, input entry_t typed_want);
    while ($urandom_range(99) < src_idle_pct) begin
      ext_if.valid <= 1'b0;
      @(posedge clk);
    end
    ext_if.valid       <= 1'b1;
    ext_if.file_id     <= x.file_id;
    ext_if.file_offset <= x.file_offset;
    ext_if.mem_pos     <= x.mem_pos;
    ext_if.length      <= x.length;
    @(posedge clk);
    while (ext_if.ready !== 1'b1) @(posedge clk);
    split_extent(x);
    if (typed) pending_entries.push_back(typed_want);
    else foreach (fresh_entries[j]) pending_entries.push_back(fresh_entries[j]);
  endtask

  // Every extent yields at least one result, so an empty queue means idle.
  task automatic wait_drained();
    ext_if.valid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
  endtask

  // Writes both registers on consecutive edges; write enable stays high
  // between them so it is never dropped and raised in one step.
  task automatic set_config(input logic [24:0] shift_data, input logic [24:0] cap_data);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SLICE_SHIFT;
    cfg_data  <= shift_data;
    @(posedge clk);
    cfg_index <= CFG_INDEX_CAPACITY;
    cfg_data  <= cap_data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tbl_shift = shift_data[5:0];
    tbl_cap   = cap_data;
  endtask

  // Result monitor and receiver. Both sample on the rising edge, before
  // the block's registers move, and pick the next ready level at random.
  always @(posedge clk) begin
    entry_t want;
    if (!rst && ent_if.valid === 1'b1 && ent_if.ready === 1'b1) begin
      results_seen++;
      if (pending_entries.size() == 0) begin
        report_mismatch("unexpected result", 64'(ent_if.entry_slot), 64'd0);
      end else begin
        want = pending_entries.pop_front();
        check_field("entry_file_id", 64'(ent_if.entry_file_id), 64'(want.entry_file_id));
        check_field("entry_file_pos", 64'(ent_if.entry_file_pos), 64'(want.entry_file_pos));
        check_field("entry_mem_pos", 64'(ent_if.entry_mem_pos), 64'(want.entry_mem_pos));
        check_field("entry_length", 64'(ent_if.entry_length), 64'(want.entry_length));
        check_field("entry_slot", 64'(ent_if.entry_slot), 64'(want.entry_slot));
        check_field("is_update", 64'(ent_if.is_update), 64'(want.is_update));
        check_field("status", 64'(ent_if.status), 64'(want.status));
        check_field("last_of_run", 64'(ent_if.last_of_run), 64'(want.last_of_run));
      end
    end
    ent_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Main sequence: reset, the directed table at the reset settings and a
  // few chosen ones, then six random phases under three idling patterns.
  initial begin
    int ph;
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_SLICE_SHIFT;
    cfg_data           <= '0;
    ext_if.valid       <= 1'b0;
    ext_if.file_id     <= '0;
    ext_if.file_offset <= '0;
    ext_if.mem_pos     <= '0;
    ext_if.length      <= '0;
    mismatches         = 0;
    results_seen       = 0;
    src_idle_pct       = 29;
    snk_idle_pct       = 87;
    tbl_shift          = SHIFT_RESET;
    tbl_cap            = CAPACITY_RESET;
    tbl_count          = '0;
    tbl_last_file      = '0;
    tbl_last_start     = '0;
    tbl_last_len       = '0;

    // At reset the table is empty, so the first extent cannot coalesce even
    // though it matches the cleared last-entry record.
    dir_table.push_back(typed_row(32'd0, 48'd0, 48'd0, 32'd1,
                                  48'd0, 48'd0, 48'd1, 24'd0, 1'b0, ST_RECORDED));
    // Continuing in the same slice lengthens entry 0; an update result carries
    // the new piece's log position.
    dir_table.push_back(typed_row(32'd0, 48'd1, 48'd100, 32'd9,
                                  48'd0, 48'd100, 48'd10, 24'd0, 1'b1, ST_RECORDED));
    // A zero-length extent coalesces and adds nothing.
    dir_table.push_back(typed_row(32'd0, 48'd10, 48'd5, 32'd0,
                                  48'd0, 48'd5, 48'd10, 24'd0, 1'b1, ST_RECORDED));
    // A zero-length extent of another file makes an empty entry.
    dir_table.push_back(typed_row(32'd7, 48'd3, 48'd9, 32'd0,
                                  48'd3, 48'd9, 48'd0, 24'd1, 1'b0, ST_RECORDED));
    // Last byte of the position space, all-ones fields.
    dir_table.push_back(typed_row(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                                  32'd1, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'd1,
                                  24'd2, 1'b0, ST_RECORDED));
    // One byte past the end of the position space.
    dir_table.push_back(typed_row(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'd0, 32'd2,
                                  48'hFFFF_FFFF_FFFF, 48'd0, 48'd2, 24'd3, 1'b0,
                                  ST_TOO_MANY));
    // Longest length at 1 MiB slices: thousands of slices.
    dir_table.push_back(typed_row(32'd1, 48'd0, 48'd0, 32'hFFFF_FFFF,
                                  48'd0, 48'd0, 48'hFFFF_FFFF, 24'd3, 1'b0, ST_TOO_MANY));
    // Exactly the piece limit, then one piece over it.
    dir_table.push_back(ext_row(32'd2, 48'd0, 48'h1000, 32'h0400_0000));
    dir_table.push_back(ext_row(32'd2, 48'h400_0000, 48'd0, 32'h0410_0000));
    // Two pieces with the log position wrapping, then a same-slice append.
    dir_table.push_back(ext_row(32'd3, 48'hF_FFF0, 48'hFFFF_FFFF_FFF0, 32'h20));
    dir_table.push_back(ext_row(32'd3, 48'h10_0010, 48'h40, 32'd8));
    // Contiguous but another file; then contiguous across a slice boundary.
    dir_table.push_back(ext_row(32'd4, 48'h10_0018, 48'h50, 32'hF_FFE8));
    dir_table.push_back(ext_row(32'd4, 48'h20_0000, 48'h60, 32'd4));
    // One-byte slices.
    dir_table.push_back(cfg_row(ROW_CONFIG, 25'd0, 25'd65536));
    dir_table.push_back(ext_row(32'd5, 48'h10, 48'd0, 32'd3));
    dir_table.push_back(ext_row(32'd5, 48'h13, 48'd3, 32'd64));
    dir_table.push_back(ext_row(32'd5, 48'h53, 48'd0, 32'd65));
    // Upper data bits set: the shift lands on 63. Largest capacity.
    dir_table.push_back(cfg_row(ROW_CONFIG, 25'h1FF_FFFF, 25'h100_0000));
    dir_table.push_back(ext_row(32'd6, 48'd0, 48'h123, 32'hFFFF_FFFF));
    dir_table.push_back(ext_row(32'd6, 48'hFFFF_FFFF, 48'h200, 32'hFFFF_FFFF));
    // A capacity of one holds nothing more.
    dir_table.push_back(cfg_row(ROW_CONFIG, 25'd40, 25'd1));
    dir_table.push_back(ext_row(32'd6, 48'h1_FFFF_FFFE, 48'd0, 32'd5));
    // Room for two entries: the split fits, the coalescing append does not.
    dir_table.push_back(cfg_row(ROW_CONFIG_REL, 25'd40, 25'd3));
    dir_table.push_back(ext_row(32'd8, 48'hFF_FFFF_FFFB, 48'h777, 32'd10));
    dir_table.push_back(ext_row(32'd8, 48'h100_0000_0005, 48'h888, 32'd1));
    // Alternating bit patterns: the first is taken, the second finds the table full.
    dir_table.push_back(cfg_row(ROW_CONFIG_REL, 25'd40, 25'd2));
    dir_table.push_back(ext_row(32'hAAAA_AAAA, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA,
                                32'h5555_5555));
    dir_table.push_back(ext_row(32'h5555_5555, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555,
                                32'hAAAA_AAAA));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_table[i]) begin
      case (dir_table[i].kind)
        ROW_EXTENT: begin
          drive_extent(dir_table[i].ext, dir_table[i].typed, dir_table[i].want);
        end
        ROW_CONFIG: begin
          wait_drained();
          set_config(dir_table[i].shift_data, dir_table[i].cap_data);
        end
        default: begin
          wait_drained();
          set_config(dir_table[i].shift_data, tbl_count + dir_table[i].cap_data);
        end
      endcase
    end

    // Random phases. Capacities near the running count make the table fill
    // up part way through a phase.
    for (ph = 0; ph < 6; ph++) begin
      wait_drained();
      case (ph)
        0: set_config(25'd20, 25'h100_0000);
        1: set_config(25'd0, tbl_count + 25'($urandom_range(30, 80)));
        2: set_config(25'd63, 25'($urandom_range(70000, 16777216)));
        3: set_config(25'd12, tbl_count + 25'($urandom_range(150, 300)));
        4: set_config(25'd40, 25'h100_0000);
        default: set_config(25'($urandom_range(1, 39)), 25'($urandom_range(20000, 16777215)));
      endcase
      src_idle_pct = (ph < 2) ? 29 : (ph < 4) ? 87 : 0;
      snk_idle_pct = (ph < 2) ? 87 : (ph < 4) ? 29 : 0;
      repeat (PHASE_ITEMS) drive_extent(make_extent(), 1'b0, '0);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_entries.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog for a block that stops producing results.
  initial begin
    #(RUN_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> sim.f
design/essc_pkg.sv
design/essc_in_if.sv
design/essc_out_if.sv
design/essc_ctrl.sv
design/essc_dp.sv
design/extent_slice_splitter_coalescer_top.sv
bench/testbench.sv
